[rtl/hbr_pkg.sv]
`default_nettype none

package hbr_pkg;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_PAD  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [7:0] STUFF_BYTE    = 8'hFF;
	localparam logic [7:0] REV_THRESHOLD = 8'h8F;
	localparam logic [6:0] LOW7_ONES     = 7'h7F;

	localparam int BUFFER_BITS_DEF = 64;
	localparam int FILL_W          = 7;
	localparam int READ_W          = 31;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic [4:0] bit_count;
	} in_item_t;

	typedef struct packed {
		logic [READ_W-1:0] read_value;
		logic              short_flag;
		logic [FILL_W-1:0] fill_level;
	} out_item_t;

endpackage

`default_nettype wire

[rtl/ht_bit_unstuffing_reader.sv]
// LSB-first bit reader with bit unstuffing for an HTJ2K block decoder.
// Input channel (in_valid / in_stall / in_item): each item either pushes a
// codestream byte, pushes a 0xFF pad byte, or reads bit_count bits from the
// low end of the bit buffer. Every item produces exactly one result item on
// the output channel (out_valid / out_stall / out_item) carrying the bits
// read, a short-read flag and the fill level after the item.
// cfg_we / cfg_wdata write the reverse_mode register; write it only while
// no item is in flight.
// An accepted item sits in the input register, and its result is loaded into
// the result register when the item advances, at which point out_valid
// rises. One item is taken per cycle while the receiver does not stall; the
// per-item buffer shift and insert is the feedback loop that sets this rate.
// Reset clears the buffer, fill count, previous byte and reverse_mode, and
// empties both registers. When the receiver stalls, the result is held and
// the input register keeps one more item; beyond that in_stall rises.
`default_nettype none

module ht_bit_unstuffing_reader #(
	parameter int BUFFER_BITS = hbr_pkg::BUFFER_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire hbr_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output hbr_pkg::out_item_t     out_item,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata
);

	logic               valid_s1;
	hbr_pkg::in_item_t  item_s1;
	logic               reverse_q;
	logic               advance;
	logic               out_valid_q;
	hbr_pkg::out_item_t out_item_q;
	hbr_pkg::out_item_t result;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			reverse_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	hbr_unit #(
		.BUFFER_BITS(BUFFER_BITS)
	) u_unit (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.reverse_mode(reverse_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.fill_level <= hbr_pkg::FILL_W'(BUFFER_BITS)))
		else $error("fill level beyond buffer size");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.short_flag) |-> (out_item.read_value == '0))
		else $error("short read returned data");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked item");

	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced item produced no result");
`endif

endmodule

`default_nettype wire

[rtl/hbr_unit.sv]
`default_nettype none

module hbr_unit #(
	parameter int BUFFER_BITS = hbr_pkg::BUFFER_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire hbr_pkg::in_item_t item,
	input  wire logic              reverse_mode,
	output hbr_pkg::out_item_t     result
);

	localparam int CNT_W = $clog2(BUFFER_BITS + 1);

	logic [BUFFER_BITS-1:0] buffer_q, buffer_d;
	logic [CNT_W-1:0]       held_q, held_d;
	logic [7:0]             prev_q, prev_d;

	logic [7:0]             push_val;
	logic                   seven;
	logic [7:0]             chunk;
	logic [CNT_W:0]         sum;
	logic                   fits;
	logic                   short_rd;
	logic [hbr_pkg::READ_W-1:0] rmask;
	logic [hbr_pkg::READ_W-1:0] rval;

	always_comb begin
		push_val = (item.kind == hbr_pkg::KIND_PAD) ? hbr_pkg::STUFF_BYTE : item.byte_value;
		if (reverse_mode) begin
			seven = (prev_q > hbr_pkg::REV_THRESHOLD) && (push_val[6:0] == hbr_pkg::LOW7_ONES);
		end else begin
			seven = (prev_q == hbr_pkg::STUFF_BYTE);
		end
		// A stuffed byte gives up its top bit.
		chunk = seven ? {1'b0, push_val[6:0]} : push_val;
		sum   = {1'b0, held_q} + (seven ? (CNT_W + 1)'(7) : (CNT_W + 1)'(8));
		fits  = sum <= (CNT_W + 1)'(BUFFER_BITS);

		short_rd = CNT_W'(item.bit_count) > held_q;
		rmask    = (hbr_pkg::READ_W'(1) << item.bit_count) - hbr_pkg::READ_W'(1);

		buffer_d = buffer_q;
		held_d   = held_q;
		prev_d   = prev_q;
		rval     = '0;

		case (item.kind)
			hbr_pkg::KIND_PUSH, hbr_pkg::KIND_PAD: begin
				if (fits) begin
					buffer_d = buffer_q | (BUFFER_BITS'(chunk) << held_q);
					held_d   = sum[CNT_W-1:0];
					if (item.kind == hbr_pkg::KIND_PUSH) begin
						prev_d = push_val;
					end
				end
			end
			hbr_pkg::KIND_READ: begin
				if (!short_rd) begin
					rval     = buffer_q[hbr_pkg::READ_W-1:0] & rmask;
					buffer_d = buffer_q >> item.bit_count;
					held_d   = held_q - CNT_W'(item.bit_count);
				end
			end
			default: begin
			end
		endcase

		result.read_value = rval;
		result.short_flag = (item.kind == hbr_pkg::KIND_READ) && short_rd;
		result.fill_level = hbr_pkg::FILL_W'(held_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_q <= '0;
			held_q   <= '0;
			prev_q   <= '0;
		end else if (step) begin
			buffer_q <= buffer_d;
			held_q   <= held_d;
			prev_q   <= prev_d;
		end
	end

endmodule

`default_nettype wire
